// ----- hdl/ycc_pkg.sv -----
// ----------------------------------------------------------------------------
// ycc_pkg: shared types and constants for the 4:2:2 YCbCr to RGB pair block
// Beat structs, chroma term bundle, BT.601 coefficients and format codes.
// ----------------------------------------------------------------------------
package ycc_pkg;

    localparam int TERM_W = 18;

    localparam logic signed [TERM_W-1:0] COEF_CR_RED   = 18'sd351;
    localparam logic signed [TERM_W-1:0] COEF_CR_GREEN = 18'sd179;
    localparam logic signed [TERM_W-1:0] COEF_CB_GREEN = 18'sd86;
    localparam logic signed [TERM_W-1:0] COEF_CB_BLUE  = 18'sd443;
    localparam logic [8:0]               CHROMA_BIAS   = 9'd128;

    localparam logic [1:0] FMT_RGB888  = 2'd0;
    localparam logic [1:0] FMT_RGB565  = 2'd1;
    localparam logic [1:0] FMT_RGB332  = 2'd2;
    localparam logic [1:0] FMT_GREY565 = 2'd3;

    typedef struct packed {
        logic [7:0] luma0;
        logic [7:0] luma1;
        logic [7:0] chroma_red;
        logic [7:0] chroma_blue;
    } pair_t;

    typedef struct packed {
        logic [23:0] pixel0;
        logic [23:0] pixel1;
    } pixels_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] red;
        logic signed [TERM_W-1:0] green;
        logic signed [TERM_W-1:0] blue;
    } chroma_terms_t;

endpackage

// ----- hdl/ycc_chroma.sv -----
// ----------------------------------------------------------------------------
// ycc_chroma: shared chroma terms
// Removes the chroma bias and forms the red, green and blue chroma products
// that both luma lanes add to their scaled luma.
// ----------------------------------------------------------------------------
module ycc_chroma
    import ycc_pkg::*;
(
    input  logic [7:0]    chroma_red,
    input  logic [7:0]    chroma_blue,
    output chroma_terms_t terms
);

    logic signed [TERM_W-1:0] cr;
    logic signed [TERM_W-1:0] cb;
    logic [8:0]               cr_c;
    logic [8:0]               cb_c;

    assign cr_c = {1'b0, chroma_red} - CHROMA_BIAS;
    assign cb_c = {1'b0, chroma_blue} - CHROMA_BIAS;

    assign cr = {{(TERM_W-9){cr_c[8]}}, cr_c};
    assign cb = {{(TERM_W-9){cb_c[8]}}, cb_c};

    assign terms.red   = cr * COEF_CR_RED;
    assign terms.green = -(cr * COEF_CR_GREEN) - (cb * COEF_CB_GREEN);
    assign terms.blue  = cb * COEF_CB_BLUE;

endmodule

// ----- hdl/ycc_lane.sv -----
// ----------------------------------------------------------------------------
// ycc_lane: one pixel lane
// Adds scaled luma to the shared chroma terms, clips each component to
// 0..255 and packs the pixel in the selected format.
// ----------------------------------------------------------------------------
module ycc_lane
    import ycc_pkg::*;
(
    input  logic [7:0]    luma,
    input  chroma_terms_t terms,
    input  logic [1:0]    output_format,
    output logic [23:0]   pixel
);

    logic signed [TERM_W-1:0] base;
    logic signed [TERM_W-1:0] sum_r;
    logic signed [TERM_W-1:0] sum_g;
    logic signed [TERM_W-1:0] sum_b;
    logic [7:0]               r;
    logic [7:0]               g;
    logic [7:0]               b;

    function automatic logic [7:0] clip(input logic signed [TERM_W-1:0] s);
        logic [7:0] c;
        if (s[TERM_W-1])
            c = 8'd0;
        else if (|s[TERM_W-2:16])
            c = 8'hFF;
        else
            c = s[15:8];
        return c;
    endfunction

    assign base  = {{(TERM_W-16){1'b0}}, luma, 8'd0};
    assign sum_r = base + terms.red;
    assign sum_g = base + terms.green;
    assign sum_b = base + terms.blue;

    assign r = clip(sum_r);
    assign g = clip(sum_g);
    assign b = clip(sum_b);

    always_comb
    begin
        unique case (output_format)
            FMT_RGB888:  pixel = {r, g, b};
            FMT_RGB565:  pixel = {8'd0, r[7:3], g[7:2], b[7:3]};
            FMT_RGB332:  pixel = {16'd0, r[7:5], g[7:5], b[7:6]};
            FMT_GREY565: pixel = {8'd0, luma[7:3], luma[7:2], luma[7:3]};
            default:     pixel = 24'd0;
        endcase
    end

endmodule

// ----- hdl/ycbcr422_to_rgb_pair.sv -----
// ----------------------------------------------------------------------------
// ycbcr422_to_rgb_pair: 4:2:2 YCbCr pair to two packed RGB pixels
// Shared chroma stage, two luma lanes, merged into one output beat.
// ----------------------------------------------------------------------------
// Throughput: one pixel pair per cycle when the output is not stalled; a
// two-stage pipeline (stage 1, then the output register) in which output
// back-pressure stalls each stage only while it holds a beat.
// Reset: asynchronous, active low; clears pipeline valids, format to rgb888.
module ycbcr422_to_rgb_pair
    import ycc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,

    input  logic       pair_valid,
    output logic       pair_ready,
    input  pair_t      pair,

    output logic       pixels_valid,
    input  logic       pixels_ready,
    output pixels_t    pixels
);

    logic [1:0]    fmt_reg;
    logic          s1_valid_reg;
    logic [7:0]    s1_luma0_reg;
    logic [7:0]    s1_luma1_reg;
    chroma_terms_t s1_terms_reg;
    chroma_terms_t terms_next;
    logic          out_valid_reg;
    pixels_t       out_reg;
    pixels_t       out_next;
    logic          adv2;
    logic          adv1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_RGB888;
        else if (cfg_valid)
            fmt_reg <= cfg_data;
    end

    ycc_chroma u_chroma (
        .chroma_red  (pair.chroma_red),
        .chroma_blue (pair.chroma_blue),
        .terms       (terms_next)
    );

    assign adv2       = !out_valid_reg || pixels_ready;
    assign adv1       = !s1_valid_reg || adv2;
    assign pair_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv1)
            s1_valid_reg <= pair_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && pair_valid)
        begin
            s1_luma0_reg <= pair.luma0;
            s1_luma1_reg <= pair.luma1;
            s1_terms_reg <= terms_next;
        end
    end

    ycc_lane u_lane0 (
        .luma          (s1_luma0_reg),
        .terms         (s1_terms_reg),
        .output_format (fmt_reg),
        .pixel         (out_next.pixel0)
    );

    ycc_lane u_lane1 (
        .luma          (s1_luma1_reg),
        .terms         (s1_terms_reg),
        .output_format (fmt_reg),
        .pixel         (out_next.pixel1)
    );

    // merge: both lanes land in one output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv2)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
            out_reg <= out_next;
    end

    assign pixels_valid = out_valid_reg;
    assign pixels       = out_reg;

`ifndef SYNTH
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv2 |=> s1_valid_reg)
        else $error("stage 1 beat dropped under stall");

    a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && pair_ready |=> s1_valid_reg)
        else $error("accepted beat not in stage 1");

    a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && adv2 |=> pixels_valid)
        else $error("stage 1 beat did not reach output");

    a_pack_565: assert property (@(posedge clk) disable iff (!rst_n)
        pixels_valid && fmt_reg != FMT_RGB888 |->
        pixels.pixel0[23:16] == 8'd0 && pixels.pixel1[23:16] == 8'd0)
        else $error("upper byte set in 16-bit packing");

    a_pack_332: assert property (@(posedge clk) disable iff (!rst_n)
        pixels_valid && fmt_reg == FMT_RGB332 |->
        pixels.pixel0[23:8] == 16'd0 && pixels.pixel1[23:8] == 16'd0)
        else $error("upper bits set in rgb332 packing");
`endif

endmodule
